/* src/ehc_pkg.sv */
`timescale 1ns / 1ps
package ehc_pkg;
   localparam int SLOT_BITS   = 6;
   localparam int LIST_DEPTH  = 16;
   localparam int REST_VALUES = 16;
   localparam int HASH_WORDS  = 6;
   localparam int NSLOTS      = 1 << SLOT_BITS;
   localparam int REST_BITS   = $clog2(REST_VALUES);
   localparam int LIST_BITS   = $clog2(LIST_DEPTH);
   localparam int CNT_BITS    = $clog2(LIST_DEPTH + 1);
   localparam int POS_BITS    = SLOT_BITS + 1;
   localparam int QDEPTH      = 4;
   localparam int QBITS       = $clog2(QDEPTH);
   localparam logic [2:0] FINAL_ROUND = 3'd7;
   localparam logic [0:0] REG_ROUND   = 1'b0;

   typedef logic [31:0] word_type;
   typedef word_type [HASH_WORDS-1:0] hash_type;

   // one classified request: new slot, its list position and how many to pair
   typedef struct packed {
      logic [19:0]           bucket;
      logic [SLOT_BITS-1:0]  slot;
      logic [REST_BITS-1:0]  rest;
      logic [CNT_BITS-1:0]   cnt;
      logic                  filed;
      logic [2:0]            round;
   } job_type;

   typedef enum logic [1:0] {BK_IDLE, BK_READ, BK_EMIT} back_state_type;

   // previous word count per round (0 for no round)
   function automatic logic [2:0] prev_words(input logic [2:0] r);
      unique case (r)
         3'd1: prev_words = 3'd6;
         3'd2: prev_words = 3'd5;
         3'd3: prev_words = 3'd4;
         3'd4: prev_words = 3'd4;
         3'd5: prev_words = 3'd3;
         3'd6: prev_words = 3'd2;
         3'd7: prev_words = 3'd1;
         default: prev_words = 3'd0;
      endcase
   endfunction

   function automatic logic [1:0] rest_offset(input logic [2:0] r);
      unique case (r)
         3'd1: rest_offset = 2'd2;
         3'd2: rest_offset = 2'd1;
         3'd3: rest_offset = 2'd0;
         3'd4: rest_offset = 2'd3;
         3'd5: rest_offset = 2'd2;
         3'd6: rest_offset = 2'd1;
         3'd7: rest_offset = 2'd0;
         default: rest_offset = 2'd0;
      endcase
   endfunction

   function automatic logic [7:0] hbyte(input hash_type h, input logic [4:0] b);
      logic [31:0] w;
      w = h[b[4:2]];
      hbyte = w[b[1:0]*8 +: 8];
   endfunction
endpackage

/* src/ehc_front.sv */
`timescale 1ns / 1ps
module ehc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic [2:0]       round,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [19:0]      bucket,
   input  ehc_pkg::hash_type hash,
   input  logic             last_in,
   output logic             q_valid,
   input  logic             q_ready,
   output ehc_pkg::job_type q_job,
   output ehc_pkg::hash_type q_hash
);
   import ehc_pkg::*;
   logic [CNT_BITS-1:0] cnt_ff [REST_VALUES];
   logic [CNT_BITS-1:0] cnt_in [REST_VALUES];
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [2:0] r;
   logic [7:0] rbyte;
   logic [REST_BITS-1:0] rest;
   logic [CNT_BITS-1:0] c;
   logic take, active, filed;

   assign r = (round == 3'd0) ? 3'd1 : round;
   assign rbyte = hbyte(hash, {3'd0, rest_offset(r)});
   assign rest = rbyte[REST_BITS-1:0];
   assign c = cnt_ff[rest];
   assign in_ready = q_ready;
   assign take = in_valid && in_ready;
   assign active = pos_ff < POS_BITS'(NSLOTS);
   assign filed = active && (c < CNT_BITS'(LIST_DEPTH));

   // hand every stored slot to the back end; it writes the store and the list
   assign q_valid = take && active;
   assign q_job = '{bucket: bucket, slot: pos_ff[SLOT_BITS-1:0], rest: rest,
                    cnt: filed ? c : '0, filed: filed, round: r};
   assign q_hash = hash;

   always_comb begin
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      if (take) begin
         if (filed) cnt_in[rest] = c + 1'b1;
         if (active) pos_in = pos_ff + 1'b1;
         if (last_in) begin
            for (int i = 0; i < REST_VALUES; i++) cnt_in[i] = '0;
            pos_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REST_VALUES; i++) cnt_ff[i] <= '0;
         pos_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
      end
   end
endmodule

/* src/ehc_queue.sv */
`timescale 1ns / 1ps
module ehc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              w_valid,
   output logic              w_ready,
   input  ehc_pkg::job_type  w_job,
   input  ehc_pkg::hash_type w_hash,
   output logic              r_valid,
   input  logic              r_ready,
   output ehc_pkg::job_type  r_job,
   output ehc_pkg::hash_type r_hash
);
   import ehc_pkg::*;
   job_type  job_ff  [QDEPTH];
   hash_type hash_ff [QDEPTH];
   logic [QBITS-1:0] wp_ff, rp_ff;
   logic [QBITS:0]   n_ff;
   logic push, pop;

   assign w_ready = n_ff < (QBITS+1)'(QDEPTH);
   assign r_valid = n_ff != '0;
   assign push = w_valid && w_ready;
   assign pop  = r_valid && r_ready;
   assign r_job  = job_ff[rp_ff];
   assign r_hash = hash_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         job_ff[wp_ff]  <= w_job;
         hash_ff[wp_ff] <= w_hash;
      end
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; n_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop)  rp_ff <= rp_ff + 1'b1;
         n_ff <= n_ff + (QBITS+1)'(push) - (QBITS+1)'(pop);
      end
   end
endmodule

/* src/ehc_back.sv */
`timescale 1ns / 1ps
module ehc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              j_valid,
   output logic              j_ready,
   input  ehc_pkg::job_type  j_job,
   input  ehc_pkg::hash_type j_hash,
   output logic              o_valid,
   input  logic              o_ready,
   output logic [31:0]       o_tree_ref,
   output logic [19:0]       o_xor_bucket,
   output ehc_pkg::word_type [4:0] o_xor_word,
   output logic              o_is_candidate,
   output logic              o_last
);
   import ehc_pkg::*;
   localparam int LADDR = REST_BITS + LIST_BITS;

   logic [SLOT_BITS-1:0] list_mem [REST_VALUES*LIST_DEPTH];
   hash_type store_mem [NSLOTS];

   back_state_type st_ff, st_in;
   job_type  job_ff;
   hash_type h1_ff;
   logic [CNT_BITS-1:0] k_ff, k_in;
   logic [1:0] ph_ff, ph_in;
   logic [SLOT_BITS-1:0] s0_rd_ff, s0_ff;
   hash_type h0_rd_ff;
   logic take;
   logic [LADDR-1:0] lraddr, lwaddr;

   // held result of the current slot, passed on once the next one is known
   logic hv_ff, hv_in, hc_ff, hc_in;
   logic [31:0] htr_ff, htr_in;
   logic [19:0] hb_ff, hb_in;
   word_type [4:0] hw_ff, hw_in;

   logic ov_ff, ov_in, ol_ff, ol_in, oc_ff, oc_in;
   logic [31:0] otr_ff, otr_in;
   logic [19:0] ob_ff, ob_in;
   word_type [4:0] ow_ff, ow_in;

   logic [2:0] pw, nw, dd;
   logic [1:0] bo;
   logic [4:0] bsel;
   logic [7:0] xb1, xb2, xb3;
   logic fin, eq, keep, decide, advance, last_pair, out_free;
   hash_type x;

   assign take = j_valid && j_ready;
   assign lraddr = {job_ff.rest, k_ff[LIST_BITS-1:0]};
   assign lwaddr = {j_job.rest, j_job.cnt[LIST_BITS-1:0]};

   // list read then store read: two registered reads, the store read addressed by the registered list read
   always_ff @(posedge clock) begin
      if (take && j_job.filed) list_mem[lwaddr] <= j_job.slot;
      s0_rd_ff <= list_mem[lraddr];
      if (take) store_mem[j_job.slot] <= j_hash;
      h0_rd_ff <= store_mem[s0_rd_ff];
      s0_ff <= s0_rd_ff;
   end

   assign pw  = prev_words(job_ff.round);
   assign bo  = rest_offset(job_ff.round);
   assign fin = job_ff.round == FINAL_ROUND;
   assign nw  = fin ? 3'd0 : prev_words(job_ff.round + 3'd1);
   assign dd  = pw - nw;
   always_comb begin
      for (int i = 0; i < HASH_WORDS; i++) x[i] = h0_rd_ff[i] ^ h1_ff[i];
   end
   assign bsel = {3'd0, bo};
   assign xb1 = hbyte(x, bsel + 5'd1);
   assign xb2 = hbyte(x, bsel + 5'd2);
   assign xb3 = hbyte(x, bsel + 5'd3);
   assign eq = h0_rd_ff[pw - 3'd1] == h1_ff[pw - 3'd1];
   assign keep = fin ? eq : !eq;
   assign out_free = !ov_ff || o_ready;
   // phase 0 reads list[k], phase 1 reads the store, phase 2 compares
   assign decide = (st_ff == BK_READ) && (ph_ff == 2'd2);
   // a kept pair must first pass the held result on to the output
   assign advance = decide && (!keep || !hv_ff || out_free);
   assign last_pair = (k_ff + 1'b1) >= job_ff.cnt;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         BK_IDLE: if (j_valid && j_job.cnt != '0) st_in = BK_READ;
         BK_READ: if (advance && last_pair) st_in = BK_EMIT;
         BK_EMIT: if (!hv_ff || out_free) st_in = BK_IDLE;
         default: st_in = BK_IDLE;
      endcase
   end

   always_comb begin
      j_ready = (st_ff == BK_IDLE);
      ph_in = ph_ff; k_in = k_ff;
      hv_in = hv_ff; htr_in = htr_ff; hb_in = hb_ff; hw_in = hw_ff; hc_in = hc_ff;
      ov_in = ov_ff && !o_ready;
      otr_in = otr_ff; ob_in = ob_ff; ow_in = ow_ff; oc_in = oc_ff; ol_in = ol_ff;
      if (take) begin
         k_in = '0;
         ph_in = '0;
      end
      if (st_ff == BK_READ && ph_ff != 2'd2) ph_in = ph_ff + 2'd1;
      if (advance) begin
         ph_in = '0;
         k_in = k_ff + 1'b1;
         if (keep) begin
            if (hv_ff) begin
               ov_in = 1'b1;
               otr_in = htr_ff; ob_in = hb_ff; ow_in = hw_ff; oc_in = hc_ff;
               ol_in = 1'b0;
            end
            hv_in = 1'b1;
            htr_in = {job_ff.bucket, s0_ff, job_ff.slot};
            hc_in = fin;
            hb_in = '0;
            hw_in = '0;
            if (!fin) begin
               hb_in = {xb1, xb2, xb3[7:4]};
               for (int w = 0; w < 5; w++)
                  if (3'(w) < nw) hw_in[w] = x[3'(w) + dd];
            end
         end
      end
      // release the held result as the last one of the slot
      if (st_ff == BK_EMIT && hv_ff && out_free) begin
         ov_in = 1'b1;
         otr_in = htr_ff; ob_in = hb_ff; ow_in = hw_ff; oc_in = hc_ff;
         ol_in = 1'b1;
         hv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BK_IDLE; ph_ff <= '0; k_ff <= '0; hv_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ph_ff <= ph_in; k_ff <= k_in; hv_ff <= hv_in; ov_ff <= ov_in;
      end
      if (take) begin
         job_ff <= j_job;
         h1_ff <= j_hash;
      end
      htr_ff <= htr_in; hb_ff <= hb_in; hw_ff <= hw_in; hc_ff <= hc_in;
      otr_ff <= otr_in; ob_ff <= ob_in; ow_ff <= ow_in; oc_ff <= oc_in; ol_ff <= ol_in;
   end

   assign o_valid = ov_ff;
   assign o_tree_ref = otr_ff;
   assign o_xor_bucket = ob_ff;
   assign o_xor_word = ow_ff;
   assign o_is_candidate = oc_ff;
   assign o_last = ol_ff;
endmodule

/* src/equihash_bucket_collision_round_unit.sv */
`timescale 1ns / 1ps
// Equihash 192,7 collision round for one bucket. The front end takes a slot request per
// cycle while its four-entry queue has room, files it under its rest nibble while that
// list has room and queues a job for each of the first 64 slots of a bucket; the back end
// takes a job, then for each earlier slot of that list reads the list, reads the store and
// compares, and then releases the held last result, if any; rsp_ready can hold a result
// back. Each result is held until the next one of its slot is known, so results leave one
// pair late. Write round_number only while nothing is in flight.
module equihash_bucket_collision_round_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [0:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [19:0] req_bucket_id,
   input  logic [31:0] req_hash_word0,
   input  logic [31:0] req_hash_word1,
   input  logic [31:0] req_hash_word2,
   input  logic [31:0] req_hash_word3,
   input  logic [31:0] req_hash_word4,
   input  logic [31:0] req_hash_word5,
   input  logic        req_last_in_bucket,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_tree_ref,
   output logic [19:0] rsp_xor_bucket,
   output logic [31:0] rsp_xor_word0,
   output logic [31:0] rsp_xor_word1,
   output logic [31:0] rsp_xor_word2,
   output logic [31:0] rsp_xor_word3,
   output logic [31:0] rsp_xor_word4,
   output logic        rsp_is_candidate,
   output logic        rsp_last
);
   import ehc_pkg::*;
   logic [2:0] round_ff;
   hash_type hash, qh, bh;
   job_type qj, bj;
   logic qv, qr, bv, br;
   word_type [4:0] xw;

   assign csr_pready = 1'b1;
   assign csr_prdata = {29'd0, round_ff};
   always_ff @(posedge clock) begin
      if (reset) round_ff <= 3'd1;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_ROUND)
         round_ff <= csr_pwdata[2:0];
   end

   assign hash = {req_hash_word5, req_hash_word4, req_hash_word3,
                  req_hash_word2, req_hash_word1, req_hash_word0};

   ehc_front u_front (.clock, .reset, .round(round_ff), .in_valid(req_valid),
      .in_ready(req_ready), .bucket(req_bucket_id), .hash, .last_in(req_last_in_bucket),
      .q_valid(qv), .q_ready(qr), .q_job(qj), .q_hash(qh));

   ehc_queue u_queue (.clock, .reset, .w_valid(qv), .w_ready(qr), .w_job(qj),
      .w_hash(qh), .r_valid(bv), .r_ready(br), .r_job(bj), .r_hash(bh));

   ehc_back u_back (.clock, .reset, .j_valid(bv), .j_ready(br), .j_job(bj),
      .j_hash(bh),
      .o_valid(rsp_valid), .o_ready(rsp_ready), .o_tree_ref(rsp_tree_ref),
      .o_xor_bucket(rsp_xor_bucket), .o_xor_word(xw),
      .o_is_candidate(rsp_is_candidate), .o_last(rsp_last));

   assign rsp_xor_word0 = xw[0];
   assign rsp_xor_word1 = xw[1];
   assign rsp_xor_word2 = xw[2];
   assign rsp_xor_word3 = xw[3];
   assign rsp_xor_word4 = xw[4];
endmodule

/* sim/tb_equihash_bucket_collision_round_unit.sv */
`timescale 1ns / 1ps
module tb_equihash_bucket_collision_round_unit;
   import ehc_pkg::*;

   localparam logic [0:0] ADDR_ROUND = 1'b0;
   localparam int DRAIN_CYCLES = 400;

   typedef struct {
      logic [19:0] bucket;
      logic [31:0] w [HASH_WORDS];
      logic        last_in_bucket;
   } slot_req_t;

   typedef struct {
      logic [31:0] tree_ref;
      logic [19:0] xor_bucket;
      logic [31:0] xw [5];
      logic        is_candidate;
      logic        last;
   } pair_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [0:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [19:0] req_bucket_id = '0;
   logic [31:0] req_hash_word0 = '0, req_hash_word1 = '0, req_hash_word2 = '0;
   logic [31:0] req_hash_word3 = '0, req_hash_word4 = '0, req_hash_word5 = '0;
   logic        req_last_in_bucket = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_tree_ref;
   logic [19:0] rsp_xor_bucket;
   logic [31:0] rsp_xor_word0, rsp_xor_word1, rsp_xor_word2, rsp_xor_word3, rsp_xor_word4;
   logic        rsp_is_candidate, rsp_last;

   equihash_bucket_collision_round_unit u_top (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [2:0]  round_reg = 3'd1;
   logic [31:0] hash_store [NSLOTS][HASH_WORDS];
   logic [5:0]  rest_lists [REST_VALUES][LIST_DEPTH];
   int          rest_fill [REST_VALUES];
   int          next_slot;

   slot_req_t   pending_slots [$];
   pair_rsp_t   expected_pairs [$];
   int          error_count = 0;
   bit          stim_done = 0;
   bit          calm = 0;
   int          req_gap = 0, rsp_stall = 0;

   // accepted flag seen at the rising edge, used by the driver at the next falling edge
   logic req_ready_q = 1'b0;

   function automatic logic [7:0] slot_byte(int s, int b);
      return hash_store[s][b >> 2][(b & 3) * 8 +: 8];
   endfunction

   task automatic predict_pairs(input slot_req_t it);
      int r, pw, bo, nw, d, s1, rv, cnt, s0;
      bit fin, eq;
      pair_rsp_t p;
      int first_idx;
      int pw_tab [8], bo_tab [8];
      pw_tab = '{0, 6, 5, 4, 4, 3, 2, 1};
      bo_tab = '{0, 2, 1, 0, 3, 2, 1, 0};
      r = (round_reg == 0) ? 1 : round_reg;
      pw = pw_tab[r];
      bo = bo_tab[r];
      fin = (r == FINAL_ROUND);
      nw = fin ? 0 : pw_tab[r + 1];
      d = pw - nw;
      first_idx = expected_pairs.size();
      if (next_slot < NSLOTS) begin
         s1 = next_slot;
         for (int w = 0; w < HASH_WORDS; w++) hash_store[s1][w] = it.w[w];
         rv = slot_byte(s1, bo) & 4'hf;
         cnt = rest_fill[rv];
         if (cnt < LIST_DEPTH) begin
            rest_lists[rv][cnt] = s1[5:0];
            rest_fill[rv] = cnt + 1;
            for (int k = 0; k < cnt; k++) begin
               s0 = rest_lists[rv][k];
               eq = hash_store[s0][pw - 1] == hash_store[s1][pw - 1];
               if (fin ? !eq : eq) continue;
               p.tree_ref = {it.bucket, 12'd0} | (s0 << 6) | s1;
               p.xor_bucket = '0;
               for (int w = 0; w < 5; w++) p.xw[w] = '0;
               p.is_candidate = fin;
               p.last = 1'b0;
               if (!fin) begin
                  p.xor_bucket = {slot_byte(s0, bo + 1) ^ slot_byte(s1, bo + 1), 12'd0}
                     | ((slot_byte(s0, bo + 2) ^ slot_byte(s1, bo + 2)) << 4)
                     | ((slot_byte(s0, bo + 3) ^ slot_byte(s1, bo + 3)) >> 4);
                  for (int w = d; w < pw; w++)
                     p.xw[w - d] = hash_store[s0][w] ^ hash_store[s1][w];
               end
               expected_pairs.push_back(p);
            end
         end
         next_slot = s1 + 1;
      end
      if (expected_pairs.size() > first_idx)
         expected_pairs[expected_pairs.size() - 1].last = 1'b1;
      if (it.last_in_bucket) begin
         for (int i = 0; i < REST_VALUES; i++) rest_fill[i] = 0;
         next_slot = 0;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h want %h", what, got, want);
      error_count++;
   endtask

   task automatic write_round(input logic [2:0] r);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= ADDR_ROUND;
      csr_pwdata <= {29'd0, r};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      round_reg = r;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   // wait until every request went in and every expected pair came out
   task automatic drain();
      while (pending_slots.size() != 0 || req_valid || expected_pairs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic slot_req_t rand_slot(logic [19:0] bkt, int rest_span, bit lastf);
      slot_req_t it;
      it.bucket = bkt;
      for (int w = 0; w < HASH_WORDS; w++) it.w[w] = $urandom;
      // narrow the low nibble of every byte, rest nibble included, so lists fill and collide
      for (int w = 0; w < HASH_WORDS; w++)
         for (int b = 0; b < 4; b++)
            it.w[w][b * 8 +: 4] = $urandom_range(0, rest_span);
      if ($urandom_range(0, 3) == 0)
         for (int w = 0; w < HASH_WORDS; w++) it.w[w] = $urandom_range(0, 3) * 32'h0101_0101;
      it.last_in_bucket = lastf;
      return it;
   endfunction

   task automatic queue_bucket(int n, int rest_span);
      logic [19:0] bkt;
      bkt = $urandom;
      for (int i = 0; i < n; i++)
         pending_slots.push_back(rand_slot(bkt, rest_span, i == n - 1));
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_ready_q) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_slots.size() != 0) begin
               slot_req_t it;
               it = pending_slots.pop_front();
               req_valid <= 1'b1;
               req_bucket_id <= it.bucket;
               req_hash_word0 <= it.w[0]; req_hash_word1 <= it.w[1];
               req_hash_word2 <= it.w[2]; req_hash_word3 <= it.w[3];
               req_hash_word4 <= it.w[4]; req_hash_word5 <= it.w[5];
               req_last_in_bucket <= it.last_in_bucket;
               if (!calm && $urandom_range(0, 4) == 0) req_gap <= $urandom_range(1, 3);
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) rsp_stall <= $urandom_range(1, 3);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      req_ready_q <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            slot_req_t it;
            it.bucket = req_bucket_id;
            it.w[0] = req_hash_word0; it.w[1] = req_hash_word1; it.w[2] = req_hash_word2;
            it.w[3] = req_hash_word3; it.w[4] = req_hash_word4; it.w[5] = req_hash_word5;
            it.last_in_bucket = req_last_in_bucket;
            predict_pairs(it);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pairs.size() == 0) begin
               report_mismatch("unexpected pair", rsp_tree_ref, 32'd0);
            end else begin
               pair_rsp_t e;
               e = expected_pairs.pop_front();
               if (rsp_tree_ref !== e.tree_ref)
                  report_mismatch("tree_ref", rsp_tree_ref, e.tree_ref);
               if (rsp_xor_bucket !== e.xor_bucket)
                  report_mismatch("xor_bucket", rsp_xor_bucket, e.xor_bucket);
               if (rsp_xor_word0 !== e.xw[0]) report_mismatch("xor_word0", rsp_xor_word0, e.xw[0]);
               if (rsp_xor_word1 !== e.xw[1]) report_mismatch("xor_word1", rsp_xor_word1, e.xw[1]);
               if (rsp_xor_word2 !== e.xw[2]) report_mismatch("xor_word2", rsp_xor_word2, e.xw[2]);
               if (rsp_xor_word3 !== e.xw[3]) report_mismatch("xor_word3", rsp_xor_word3, e.xw[3]);
               if (rsp_xor_word4 !== e.xw[4]) report_mismatch("xor_word4", rsp_xor_word4, e.xw[4]);
               if (rsp_is_candidate !== e.is_candidate)
                  report_mismatch("is_candidate", rsp_is_candidate, e.is_candidate);
               if (rsp_last !== e.last) report_mismatch("last", rsp_last, e.last);
            end
         end
      end
   end

   initial begin
      slot_req_t it;
      for (int i = 0; i < REST_VALUES; i++) rest_fill[i] = 0;
      next_slot = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, list overflow
      it.bucket = 20'hfffff;
      for (int w = 0; w < HASH_WORDS; w++) it.w[w] = 32'hffff_ffff;
      it.last_in_bucket = 1'b0;
      pending_slots.push_back(it);
      for (int w = 0; w < HASH_WORDS; w++) it.w[w] = 32'h0;
      it.w[2] = 32'h000f_0000;
      pending_slots.push_back(it);
      it.w[5] = 32'h1234_5678;
      pending_slots.push_back(it);
      it.w[5] = 32'hedcb_a987;
      it.bucket = 20'h0;
      it.last_in_bucket = 1'b1;
      pending_slots.push_back(it);
      // overfill one rest list
      for (int i = 0; i < 19; i++) begin
         it = rand_slot(20'h5a5a5, 0, i == 18);
         it.w[0][19:16] = 4'h3;
         it.w[0][3:0] = 4'h3;
         pending_slots.push_back(it);
      end
      drain();

      // one bucket of more than 64 slots
      write_round(3'd0);
      queue_bucket(70, 15);
      drain();

      for (int r = 1; r <= 7; r++) begin
         write_round(r[2:0]);
         queue_bucket($urandom_range(6, 12), (r == 7) ? 1 : 3);
         queue_bucket($urandom_range(2, 6), 15);
         if (r == 7) queue_bucket(12, 0);
         drain();
      end

      calm = 1;
      write_round(3'd7);
      queue_bucket(12, 1);
      drain();
      write_round(3'd1);
      queue_bucket(12, 1);
      drain();

      if (error_count == 0)
         $display("equihash_bucket_collision_round_unit verification clean");
      else
         $display("equihash_bucket_collision_round_unit verification failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("equihash_bucket_collision_round_unit verification failed");
      $finish;
   end
endmodule

/* sim.f */
src/ehc_pkg.sv
src/ehc_front.sv
src/ehc_queue.sv
src/ehc_back.sv
src/equihash_bucket_collision_round_unit.sv
sim/tb_equihash_bucket_collision_round_unit.sv
